FILE: sv/assert_macros.svh
// Assertion macros shared by the vertical Sobel filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define VSF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define VSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/vsf_pkg.sv
// Package with shared widths, register codes, types and the gradient function.
package vsf_pkg;

	// Line store depth and derived column index width.
	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	// Field and register widths.
	localparam int PIX_W  = 8;
	localparam int SM_W   = 10;
	localparam int GRAD_W = 8;
	localparam int FW_W   = 13;
	localparam int ROW_W  = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 1;

	// Register reset values and the width limit in register format.
	localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(640);
	localparam logic [ROW_W-1:0] FH_RESET  = ROW_W'(480);
	localparam logic [FW_W-1:0]  FW_LIMIT  = FW_W'(MAX_WIDTH);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// One column whose smoothed value is ready.
	typedef struct packed {
		logic [COL_W-1:0] x;
		logic [SM_W-1:0]  s;
		logic [ROW_W-1:0] row;
		logic             last_row;
		logic             frame_end;
	} col_event_t;

	// One result item.
	typedef struct packed {
		logic [GRAD_W-1:0] gradient;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              done;
	} result_t;

	// Difference of two smoothed values over four; negatives give zero.
	// The largest difference over four is 255, so no upper clamp is needed.
	function automatic logic [GRAD_W-1:0] grad_of(input logic [SM_W-1:0] below,
			input logic [SM_W-1:0] above);
		logic [SM_W-1:0] diff;
		diff = below - above;
		if (below <= above) begin
			return '0;
		end
		return diff[SM_W-1:SM_W-GRAD_W];
	endfunction

endpackage

FILE: sv/vsf_column.sv
// Pixel front end: horizontal smoothing, position counters and column slots.
module vsf_column (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [vsf_pkg::FW_W-1:0]        frame_width,
	input  logic [vsf_pkg::ROW_W-1:0]       frame_height,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [vsf_pkg::PIX_W-1:0]       pixel,
	output logic                            ev_valid,
	output vsf_pkg::col_event_t             ev,
	input  logic                            ev_take
);

	logic [vsf_pkg::PIX_W-1:0] left_q, centre_q;
	logic [vsf_pkg::COL_W-1:0] col_q;
	logic [vsf_pkg::ROW_W-1:0] row_q;
	logic                      va_q, vb_q;
	vsf_pkg::col_event_t       ev_a_q, ev_b_q;

	logic [vsf_pkg::FW_W-1:0]  w_eff, w_m1;
	logic [vsf_pkg::ROW_W-1:0] h_eff, h_m1;
	logic                      last_col, last_row, has_mid, has_end, accept;
	logic [vsf_pkg::SM_W-1:0]  s_mid, s_end;
	vsf_pkg::col_event_t       ev_mid, ev_end;

	// Effective frame size: zero acts as one, width saturates at the store depth.
	always_comb begin
		if (frame_width == '0) begin
			w_eff = vsf_pkg::FW_W'(1);
		end else if (frame_width > vsf_pkg::FW_LIMIT) begin
			w_eff = vsf_pkg::FW_LIMIT;
		end else begin
			w_eff = frame_width;
		end
		if (frame_height == '0) begin
			h_eff = vsf_pkg::ROW_W'(1);
		end else begin
			h_eff = frame_height;
		end
		w_m1 = w_eff - vsf_pkg::FW_W'(1);
		h_m1 = h_eff - vsf_pkg::ROW_W'(1);
	end

	assign last_col = {1'b0, col_q} >= w_m1;
	assign last_row = row_q >= h_m1;
	assign has_mid  = col_q != '0;
	assign has_end  = last_col;

	// A new pixel fits once the slots are empty or the last one leaves now.
	assign in_stall = va_q && !(ev_take && !vb_q);
	assign accept   = in_valid && !in_stall;
	assign ev_valid = va_q;
	assign ev       = ev_a_q;

	// Smoothed values: interior column and the row's last column.
	always_comb begin
		s_mid = vsf_pkg::SM_W'(left_q) + {1'b0, centre_q, 1'b0} + vsf_pkg::SM_W'(pixel);
		if (col_q == '0) begin
			s_end = {pixel, 2'b00};
		end else begin
			s_end = vsf_pkg::SM_W'(centre_q) + {1'b0, pixel, 1'b0} + vsf_pkg::SM_W'(pixel);
		end
		ev_mid.x         = col_q - vsf_pkg::COL_W'(1);
		ev_mid.s         = s_mid;
		ev_mid.row       = row_q;
		ev_mid.last_row  = last_row;
		ev_mid.frame_end = 1'b0;
		ev_end.x         = col_q;
		ev_end.s         = s_end;
		ev_end.row       = row_q;
		ev_end.last_row  = last_row;
		ev_end.frame_end = last_row;
	end

	// Slot occupancy; the interior column goes out before the last column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= 1'b0;
			vb_q <= 1'b0;
		end else if (accept) begin
			va_q <= has_mid || has_end;
			vb_q <= has_mid && has_end;
		end else if (ev_take) begin
			va_q <= vb_q;
			vb_q <= 1'b0;
		end
	end

	// Slot contents.
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_a_q <= has_mid ? ev_mid : ev_end;
			ev_b_q <= ev_end;
		end else if (ev_take) begin
			ev_a_q <= ev_b_q;
		end
	end

	// Pixel history and raster position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			centre_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (accept) begin
			left_q   <= has_mid ? centre_q : pixel;
			centre_q <= pixel;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + vsf_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + vsf_pkg::COL_W'(1);
			end
		end
	end

endmodule

FILE: sv/vsf_linebuf.sv
// Line stores of the two previous smoothed rows and the gradient result stage.
module vsf_linebuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ev_valid,
	input  vsf_pkg::col_event_t ev,
	output logic                ev_take,
	output logic                res_valid,
	output vsf_pkg::result_t    res,
	input  logic                res_take
);

	localparam int ENT_W = 2 * vsf_pkg::SM_W;

	// Each entry holds the row above in the upper half, two above in the lower.
	logic [ENT_W-1:0] mem [vsf_pkg::MAX_WIDTH];

	logic                v_s2, ph_s2, byp_hit_s2;
	vsf_pkg::col_event_t ev_s2;
	logic [ENT_W-1:0]    rd_s2, byp_data_s2;

	logic [ENT_W-1:0]        entry, wr_data;
	logic [vsf_pkg::SM_W-1:0] a, b;
	logic                    need_p, need_f, cur_pend, has_res, last_res, s2_done;

	// Entry for this column, with the write of the column event just before forwarded when it hits the same column.
	assign entry   = byp_hit_s2 ? byp_data_s2 : rd_s2;
	assign a       = entry[ENT_W-1:vsf_pkg::SM_W];
	assign b       = entry[vsf_pkg::SM_W-1:0];
	assign wr_data = {ev_s2.s, a};

	assign need_p   = ev_s2.row != '0;
	assign need_f   = ev_s2.last_row;
	assign cur_pend = need_p && !ph_s2;
	assign has_res  = need_p || need_f;
	assign last_res = cur_pend ? !need_f : 1'b1;

	assign res_valid = v_s2 && has_res;
	assign s2_done   = v_s2 && (!has_res || (res_take && last_res));
	assign ev_take   = ev_valid && (!v_s2 || s2_done);

	// Pending row result first, then the final row result on the last row.
	always_comb begin
		res.col = ev_s2.x;
		if (cur_pend) begin
			res.gradient = vsf_pkg::grad_of(ev_s2.s, (ev_s2.row == vsf_pkg::ROW_W'(1)) ? a : b);
			res.row      = ev_s2.row - vsf_pkg::ROW_W'(1);
			res.done     = 1'b0;
		end else begin
			res.gradient = vsf_pkg::grad_of(ev_s2.s, (ev_s2.row == '0) ? ev_s2.s : a);
			res.row      = ev_s2.row;
			res.done     = ev_s2.frame_end;
		end
	end

	// Store write once the column has delivered all its results.
	always_ff @(posedge clk) begin
		if (s2_done) begin
			mem[ev_s2.x] <= wr_data;
		end
	end

	// Registered read for the column entering the result stage.
	always_ff @(posedge clk) begin
		if (ev_take) begin
			rd_s2 <= mem[ev.x];
		end
	end

	// Result stage payload and the forwarding match.
	always_ff @(posedge clk) begin
		if (ev_take) begin
			ev_s2       <= ev;
			byp_hit_s2  <= s2_done && (ev_s2.x == ev.x);
			byp_data_s2 <= wr_data;
		end
	end

	// Result stage occupancy and which of its results is next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			ph_s2 <= 1'b0;
		end else begin
			if (ev_take) begin
				v_s2 <= 1'b1;
			end else if (s2_done) begin
				v_s2 <= 1'b0;
			end
			if (ev_take || s2_done) begin
				ph_s2 <= 1'b0;
			end else if (res_valid && res_take) begin
				ph_s2 <= 1'b1;
			end
		end
	end

endmodule

FILE: sv/vertical_sobel_filter_top.sv
// The result for column x is registered in the column slot, the result stage and the output
// register in turn after pixel x+1 is accepted (the row's last pixel for the last column).
// Throughput: one transaction per cycle in the row interior while out_stall is low; a row
// end or a last-row column delivers its results one at a time, up to four for one pixel, set
// by the single result stage and output register. Reset clears counters, handshakes and
// registers to 640x480; the line stores are not cleared and need no clearing pass.
`include "assert_macros.svh"

module vertical_sobel_filter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [vsf_pkg::IDX_W-1:0]     cfg_index,
	input  logic [vsf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [vsf_pkg::PIX_W-1:0]     pixel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [vsf_pkg::GRAD_W-1:0]    gradient,
	output logic [vsf_pkg::COL_W-1:0]     out_col,
	output logic [vsf_pkg::ROW_W-1:0]     out_row,
	output logic                          frame_done
);

	logic [vsf_pkg::FW_W-1:0]  width_q;
	logic [vsf_pkg::ROW_W-1:0] height_q;

	logic                ev_valid, ev_take, res_valid, res_take;
	vsf_pkg::col_event_t ev;
	vsf_pkg::result_t    res, out_q;
	logic                out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= vsf_pkg::FW_RESET;
			height_q <= vsf_pkg::FH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				vsf_pkg::REG_FRAME_WIDTH: begin
					width_q <= cfg_data[vsf_pkg::FW_W-1:0];
				end
				vsf_pkg::REG_FRAME_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	vsf_column u_column (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (width_q),
		.frame_height (height_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.ev_valid     (ev_valid),
		.ev           (ev),
		.ev_take      (ev_take)
	);

	vsf_linebuf u_linebuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev        (ev),
		.ev_take   (ev_take),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// Output register: refilled whenever it is empty or its transaction completes.
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign gradient   = out_q.gradient;
	assign out_col    = out_q.col;
	assign out_row    = out_q.row;
	assign frame_done = out_q.done;

	// A column waiting for the result stage keeps its slot unchanged.
	`VSF_ASSERT_NEXT(a_event_held, ev_valid && !ev_take, ev_valid && $stable(ev), "column event lost while waiting")
	// A result not yet taken by the output register stays offered and unchanged.
	`VSF_ASSERT_NEXT(a_result_held, res_valid && !res_take, res_valid && $stable(res), "result changed before it was taken")
	// A result taken by the output register is offered on the outputs next cycle.
	`VSF_ASSERT_NEXT(a_result_shown, res_valid && res_take, out_valid, "taken result not presented")
	// No column enters the result stage while the result stage still holds results.
	`VSF_ASSERT_SAME(a_no_overrun, ev_take && res_valid, res_take, "result stage overwritten")

endmodule
